// File: sv/cs_pkg.sv
package cs_pkg;

  // Fixed widths of the stream fields
  localparam int KEY_W = 8;

  // Defaults for the top-level parameters
  localparam int KEY_BITS_DEF  = 8;
  localparam int MAX_ITEMS_DEF = 64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_RD,
    ST_LOAD,
    ST_EMIT
  } cs_state_t;

endpackage

// File: sv/cs_bin_ram.sv
module cs_bin_ram #(
  parameter int ADDR_BITS = 8,
  parameter int DATA_BITS = 7
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/counting_sort.sv
// Batch counting sort of unsigned keys.
// Input stream s_axis_*: one key per transfer in tdata, tlast marks the final
// key of a batch. Output stream m_axis_*: the keys of the batch in ascending
// order, one per transfer; tlast marks the final one, tuser is the overflow
// flag (keys past MAX_ITEMS were dropped from this batch).
// A batch holds up to MAX_ITEMS keys; further keys are dropped.
// Flow: a stored key reads its bin counter from the histogram RAM (one read
// and one write port) and writes it back incremented; a dropped key needs no
// RAM write. After the last key the sequencer walks bins 0 up to the largest
// key: each bin is read, then cleared, then its results are emitted one by
// one. s_axis_tready is low while a key is being stored and during the scan.
// Results pass through an output register: the scan holds while m_axis_tready
// is low, and input is taken again as soon as the scan ends, even while the
// final result still waits.
// Reset: after rst the block runs a clearing pass over all 2**KEY_BITS bins,
// one per cycle, before it raises s_axis_tready.
module counting_sort #(
  parameter int KEY_BITS  = cs_pkg::KEY_BITS_DEF,
  parameter int MAX_ITEMS = cs_pkg::MAX_ITEMS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [cs_pkg::KEY_W-1:0] s_axis_tdata,   // [7:0] key
  input  logic                     s_axis_tlast,   // last_in
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [cs_pkg::KEY_W-1:0] m_axis_tdata,   // [7:0] sorted_key
  output logic                     m_axis_tlast,   // last_out
  output logic                     m_axis_tuser    // [0] overflow
);

  import cs_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);

  cs_state_t state, state_next;

  logic [KEY_BITS-1:0] addr, addr_next;
  logic [KEY_BITS-1:0] max_key, max_key_next;
  logic [KEY_BITS-1:0] hold_idx, hold_idx_next;
  logic [CNT_BITS-1:0] item_total, item_total_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic                dropped, dropped_next;
  logic                last_pend, last_pend_next;
  logic                out_valid, out_valid_next;
  logic [KEY_W-1:0]    out_key, out_key_next;
  logic                out_last, out_last_next;
  logic                out_ovf, out_ovf_next;

  logic                mem_we;
  logic [KEY_BITS-1:0] mem_waddr, mem_raddr;
  logic [CNT_BITS-1:0] mem_wdata, mem_rdata;

  // shared counter adder: bin increment and per-bin count-down
  logic [CNT_BITS-1:0] alu_a, alu_b, alu_sum;

  logic [KEY_BITS-1:0] key_idx;
  logic                in_fire;
  logic                out_free;

  assign key_idx  = KEY_BITS'(s_axis_tdata);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign alu_sum  = alu_a + alu_b;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_key;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_ovf;

  cs_bin_ram #(
    .ADDR_BITS(KEY_BITS),
    .DATA_BITS(CNT_BITS)
  ) u_bins (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_next      = state;
    addr_next       = addr;
    max_key_next    = max_key;
    hold_idx_next   = hold_idx;
    item_total_next = item_total;
    cnt_next        = cnt;
    dropped_next    = dropped;
    last_pend_next  = last_pend;
    out_valid_next  = out_valid && !m_axis_tready;
    out_key_next    = out_key;
    out_last_next   = out_last;
    out_ovf_next    = out_ovf;
    mem_we          = 1'b0;
    mem_waddr       = addr;
    mem_wdata       = '0;
    mem_raddr       = addr;
    alu_a           = mem_rdata;
    alu_b           = CNT_BITS'(1);

    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (addr == '1) begin
          addr_next  = '0;
          state_next = ST_IDLE;
        end else begin
          addr_next = addr + KEY_BITS'(1);
        end
      end
      ST_IDLE: begin
        mem_raddr = key_idx;
        if (in_fire) begin
          last_pend_next = s_axis_tlast;
          if (item_total < CNT_BITS'(MAX_ITEMS)) begin
            hold_idx_next   = key_idx;
            item_total_next = item_total + CNT_BITS'(1);
            if (key_idx > max_key) begin
              max_key_next = key_idx;
            end
            state_next = ST_INC;
          end else begin
            dropped_next = 1'b1;
            if (s_axis_tlast) begin
              state_next = ST_RD;
            end
          end
        end
      end
      ST_INC: begin
        mem_we     = 1'b1;
        mem_waddr  = hold_idx;
        mem_wdata  = alu_sum;
        state_next = last_pend ? ST_RD : ST_IDLE;
      end
      ST_RD: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        // bin is read out; clear it for the next batch
        cnt_next = mem_rdata;
        mem_we   = 1'b1;
        if (mem_rdata == '0) begin
          addr_next  = addr + KEY_BITS'(1);
          state_next = ST_RD;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        alu_a = cnt;
        alu_b = '1;
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_key_next    = KEY_W'(addr);
          out_last_next   = (item_total == CNT_BITS'(1));
          out_ovf_next    = dropped;
          cnt_next        = alu_sum;
          item_total_next = item_total - CNT_BITS'(1);
          if (item_total == CNT_BITS'(1)) begin
            max_key_next = '0;
            dropped_next = 1'b0;
            addr_next    = '0;
            state_next   = ST_IDLE;
          end else if (cnt == CNT_BITS'(1)) begin
            addr_next  = addr + KEY_BITS'(1);
            state_next = ST_RD;
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
        addr_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      addr       <= '0;
      max_key    <= '0;
      item_total <= '0;
      dropped    <= 1'b0;
      last_pend  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      addr       <= addr_next;
      max_key    <= max_key_next;
      item_total <= item_total_next;
      dropped    <= dropped_next;
      last_pend  <= last_pend_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    hold_idx <= hold_idx_next;
    cnt      <= cnt_next;
    out_key  <= out_key_next;
    out_last <= out_last_next;
    out_ovf  <= out_ovf_next;
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    item_total <= CNT_BITS'(MAX_ITEMS))
    else $error("batch count above capacity");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    dropped |-> (item_total == CNT_BITS'(MAX_ITEMS)) || (state == ST_RD) ||
                (state == ST_LOAD) || (state == ST_EMIT))
    else $error("overflow flag set on a batch that is not full");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> (addr <= max_key))
    else $error("scan walked past the largest key");

  a_emit_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (item_total != '0) && (cnt != '0))
    else $error("emitting with nothing left to emit");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free && item_total == CNT_BITS'(1)) |=>
      (max_key == '0) && !dropped && out_last)
    else $error("batch end did not reset the batch state");
`endif

endmodule

// File: tb/tb_counting_sort.sv
`timescale 1ns / 1ps

module tb_counting_sort;
  import cs_pkg::*;

  localparam int NBINS       = 1 << KEY_BITS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 2 * NBINS + 2 * MAX_ITEMS_DEF;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
  } key_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
    logic             ovf;
  } sorted_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [KEY_W-1:0] s_axis_tdata = '0;   // [7:0] key
  logic             s_axis_tlast = 1'b0; // last_in
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [KEY_W-1:0] m_axis_tdata;        // [7:0] sorted_key
  logic             m_axis_tlast;        // last_out
  logic             m_axis_tuser;        // [0] overflow

  counting_sort DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_item_t key_q[$];
  sorted_t   sorted_q[$];
  int        errors = 0;
  bit        calm = 1'b0;

  // histogram shadow
  logic [6:0]              hist [NBINS];
  logic [KEY_BITS_DEF-1:0] top_key = '0;
  int                      batch_len = 0;
  logic                    batch_ovf = 1'b0;

  initial begin
    for (int i = 0; i < NBINS; i++) hist[i] = '0;
  end

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic tally_key(input logic [KEY_W-1:0] key, input logic last);
    logic [KEY_BITS_DEF-1:0] k;
    sorted_t                 r;
    int                      n;
    k = key[KEY_BITS_DEF-1:0];
    n = 0;
    if (batch_len < MAX_ITEMS_DEF) begin
      hist[k] = hist[k] + 7'd1;
      batch_len++;
      if (k > top_key) top_key = k;
    end else begin
      batch_ovf = 1'b1;
    end
    if (last) begin
      for (int b = 0; b <= int'(top_key); b++) begin
        for (int c = 0; c < int'(hist[b]) && n < MAX_ITEMS_DEF; c++) begin
          r.key  = KEY_W'(b);
          r.last = 1'b0;
          r.ovf  = batch_ovf;
          sorted_q.push_back(r);
          n++;
        end
      end
      if (n > 0) sorted_q[sorted_q.size()-1].last = 1'b1;
      for (int i = 0; i < NBINS; i++) hist[i] = '0;
      top_key   = '0;
      batch_len = 0;
      batch_ovf = 1'b0;
    end
  endtask

  // key sender
  int unsigned tx_wait = 0;
  key_item_t   tx_item;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      tx_wait       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) tally_key(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_wait != 0) begin
          tx_wait       <= tx_wait - 1;
          s_axis_tvalid <= 1'b0;
        end else if (key_q.size() != 0) begin
          tx_item        = key_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= tx_item.key;
          s_axis_tlast  <= tx_item.last;
          tx_wait       <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sorted-key receiver
  int unsigned rx_wait = 0;
  int unsigned rx_draw;
  sorted_t     rx_exp;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (sorted_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, got key=%0d last=%0b ovf=%0b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        rx_exp = sorted_q.pop_front();
        if (m_axis_tdata !== rx_exp.key) begin
          errors++;
          $display("%0t: sorted_key mismatch, expected %0d, got %0d",
                   $time, rx_exp.key, m_axis_tdata);
        end
        if (m_axis_tlast !== rx_exp.last) begin
          errors++;
          $display("%0t: last_out mismatch, expected %0b, got %0b",
                   $time, rx_exp.last, m_axis_tlast);
        end
        if (m_axis_tuser !== rx_exp.ovf) begin
          errors++;
          $display("%0t: overflow mismatch, expected %0b, got %0b",
                   $time, rx_exp.ovf, m_axis_tuser);
        end
      end
      rx_draw        = pick_gap();
      rx_wait       <= rx_draw;
      m_axis_tready <= (rx_draw == 0);
    end else if (rx_wait != 0) begin
      rx_wait       <= rx_wait - 1;
      m_axis_tready <= (rx_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_counting_sort: errors");
        $finish;
      end
    end
  end

  task automatic put_key(input int k, input bit last);
    key_item_t it;
    it.key  = KEY_W'(k);
    it.last = last;
    key_q.push_back(it);
  endtask

  // narrow batches pile keys into a few neighboring bins
  task automatic add_batch(input int len, input bit narrow);
    int base;
    base = $urandom_range(0, 255 - 7);
    for (int i = 0; i < len; i++) begin
      if (narrow) put_key(base + $urandom_range(0, 7), i == len - 1);
      else        put_key($urandom_range(0, 255), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (key_q.size() != 0 || s_axis_tvalid || sorted_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    int len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // single-key batches at both ends of the key range
    put_key(0, 1);
    put_key(255, 1);
    // duplicates, out of order
    put_key(5, 0); put_key(3, 0); put_key(5, 0); put_key(1, 0); put_key(3, 1);
    // every key bit toggled, largest first
    put_key(255, 0); put_key(0, 0); put_key(128, 0); put_key(1, 0);
    put_key(254, 0); put_key(127, 1);
    // one bin holds all keys
    put_key(7, 0); put_key(7, 0); put_key(7, 1);
    put_key(0, 0); put_key(0, 1);
    sent = key_q.size();

    // hold off until the directed batches have fully drained
    wait_drained();

    for (int i = 0; i < 3; i++) begin
      len = $urandom_range(1, 10);
      add_batch(len, $urandom_range(0, 1));
      sent += len;
    end

    // full batch, then a dropped key and a dropped last key
    for (int i = 0; i < 66; i++) put_key($urandom_range(0, 255), i == 65);
    sent += 66;

    while (sent < 110) begin
      len = $urandom_range(1, 10);
      add_batch(len, $urandom_range(0, 1));
      sent += len;
    end

    // back-to-back stretch on both sides
    calm = 1'b1;
    for (int i = 0; i < 4; i++) begin
      len = $urandom_range(1, 10);
      add_batch(len, $urandom_range(0, 1));
      sent += len;
    end
    wait_drained();
    calm = 1'b0;

    while (sent < 170) begin
      len = $urandom_range(1, 10);
      add_batch(len, $urandom_range(0, 1));
      sent += len;
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("tb_counting_sort: clean");
    end else begin
      $display("tb_counting_sort: errors");
    end
    $finish;
  end

endmodule
